/* rtl/waypoint_turn_move_commands_assert.svh */
// Assertion macros used by the waypoint follower checker.
// Depends on nothing; each macro expects clock in scope, all but the last also reset.
`ifndef WAYPOINT_TURN_MOVE_COMMANDS_ASSERT_SVH
`define WAYPOINT_TURN_MOVE_COMMANDS_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define WTM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define WTM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define WTM_ASSERT_NXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wtm_pkg.sv */
// Shared constants, codes and the CORDIC arctangent table of the waypoint follower.
// Depends on nothing.
package wtm_pkg;

   localparam int POS_WIDTH_DEF    = 32;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int CORDIC_ITERS_DEF = 16;

   // Each scaled displacement component sits just below 2^60.
   localparam int CORDIC_HEADROOM = 60;
   localparam logic [31:0] INV_GAIN = 32'd2608131496;

   typedef enum logic {
      CMD_TURN  = 1'b0,
      CMD_DRIVE = 1'b1
   } command_type;

   // Arctangent of 2^-idx, 2^32 counts per full turn.
   function automatic logic [31:0] atan_step(input int idx);
      logic [31:0] r;
      r = 32'd0;
      case (idx)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/wtm_cordic_cell.sv */
// One CORDIC vectoring micro-rotation with a fixed shift, registered.
// Depends on wtm_pkg for the arctangent table.
module wtm_cordic_cell
   import wtm_pkg::*;
#(
   parameter int CW  = 63,
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 a_valid,
   input  logic signed [CW-1:0] a_x,
   input  logic signed [CW-1:0] a_y,
   input  logic [31:0]          a_z,
   output logic                 q_valid,
   output logic signed [CW-1:0] q_x,
   output logic signed [CW-1:0] q_y,
   output logic [31:0]          q_z
);

   localparam logic [31:0] ATAN = atan_step(IDX);

   logic                 valid_ff;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]          z_ff, z_in;
   logic signed [CW-1:0] xs, ys;

   assign xs = a_x >>> IDX;
   assign ys = a_y >>> IDX;

   always_comb begin
      if (!a_y[CW-1]) begin
         x_in = a_x + ys;
         y_in = a_y - xs;
         z_in = a_z + ATAN;
      end else begin
         x_in = a_x - ys;
         y_in = a_y + xs;
         z_in = a_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= a_valid;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign q_valid = valid_ff;
   assign q_x     = x_ff;
   assign q_y     = y_ff;
   assign q_z     = z_ff;

endmodule

/* rtl/wtm_gain.sv */
// Removes the CORDIC gain from the vector magnitude, rounds off the guard bits
// and saturates to the distance width. Two register stages. Depends on wtm_pkg.
module wtm_gain
   import wtm_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 a_valid,
   input  logic signed [CORDIC_HEADROOM+2:0] a_x,
   output logic                 q_valid,
   output logic [POS_WIDTH:0]   q_dist
);

   localparam int CW    = CORDIC_HEADROOM + 3;
   localparam int GUARD = CORDIC_HEADROOM - POS_WIDTH;
   localparam int HB    = CW - 1 - 32;
   localparam int TW    = HB + 33;
   localparam int QW    = TW + 1 - GUARD;

   logic [CW-2:0]     mag;
   logic [HB+31:0]    hi_ff;
   logic [63:0]       lo_ff;
   logic              v1_ff, v2_ff;
   logic [TW-1:0]     t_sum;
   logic [TW:0]       rnd;
   logic [QW-1:0]     quo;
   logic [POS_WIDTH:0] dist_ff, dist_in;

   // A negative final x cannot occur for a real vector; it clamps to zero.
   assign mag = a_x[CW-1] ? '0 : a_x[CW-2:0];

   assign t_sum = TW'(hi_ff) + TW'(lo_ff[63:32]);
   assign rnd   = (TW+1)'(t_sum) + ((TW+1)'(1) << (GUARD - 1));
   assign quo   = rnd[TW:GUARD];

   always_comb begin
      if (quo[QW-1:POS_WIDTH+1] != '0) begin
         dist_in = '1;
      end else begin
         dist_in = quo[POS_WIDTH:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= a_valid;
         v2_ff <= v1_ff;
      end
      hi_ff   <= mag[CW-2:32] * INV_GAIN;
      lo_ff   <= mag[31:0] * INV_GAIN;
      dist_ff <= dist_in;
   end

   assign q_valid = v2_ff;
   assign q_dist  = dist_ff;

endmodule

/* rtl/waypoint_turn_move_commands.sv */
// Turn-drive-turn waypoint follower. Each accepted item is a waypoint (x, y in
// Q16.16, final heading as a binary angle); the block answers with up to three
// commands: turn to the bearing, drive the distance, turn to the final heading.
// Zero commands are dropped and the final one carries rsp_last_command. The
// bearing and distance come from a chain of CORDIC_ITERS vectoring cells, one
// micro-rotation per cell per cycle, followed by a two-stage gain multiplier
// and the command registers; commands leave one per cycle when the output is
// not stalled. Only one item is in flight; req_stall is high from acceptance
// through the cycle after the last command is loaded into the output register,
// while the block returns to idle. Depends on wtm_pkg and the cell and gain
// modules.
module waypoint_turn_move_commands
   import wtm_pkg::*;
#(
   parameter int POS_WIDTH    = POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
   parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [POS_WIDTH-1:0]   req_target_x,
   input  logic [POS_WIDTH-1:0]   req_target_y,
   input  logic [ANGLE_WIDTH-1:0] req_target_heading,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_command_kind,
   output logic [ANGLE_WIDTH-1:0] rsp_turn_angle,
   output logic [POS_WIDTH:0]     rsp_drive_distance,
   output logic                   rsp_last_command
);

   localparam int CW    = CORDIC_HEADROOM + 3;
   localparam int GUARD = CORDIC_HEADROOM - POS_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic signed [POS_WIDTH-1:0] pose_x_ff, pose_y_ff;
   logic [ANGLE_WIDTH-1:0]      pose_h_ff, head_ff, goal_ff, bearing_ff;
   logic                        zero_ff;
   logic signed [POS_WIDTH:0]   dx, dy;
   logic signed [POS_WIDTH+1:0] ux, uy;
   logic signed [CW-1:0]        x0_ff, y0_ff;
   logic [31:0]                 z0_ff;
   logic                        v0_ff;
   logic                        accept;

   logic                 cv [0:CORDIC_ITERS];
   logic signed [CW-1:0] cx [0:CORDIC_ITERS];
   logic signed [CW-1:0] cy [0:CORDIC_ITERS];
   logic [31:0]          cz [0:CORDIC_ITERS];

   logic                   gain_valid;
   logic [POS_WIDTH:0]     gain_dist;
   logic [31:0]            zround;
   logic [ANGLE_WIDTH-1:0] bear_sel, turn1, turn2;
   logic [POS_WIDTH:0]     dist_sel;

   logic [2:0]             pend_ff;
   logic [ANGLE_WIDTH-1:0] turn1_ff, turn2_ff;
   logic [POS_WIDTH:0]     dist_ff;

   logic                   out_v_ff;
   logic                   out_kind_ff, out_last_ff;
   logic [ANGLE_WIDTH-1:0] out_turn_ff;
   logic [POS_WIDTH:0]     out_dist_ff;
   logic                   out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !out_v_ff || !rsp_stall;

   assign dx = {req_target_x[POS_WIDTH-1], req_target_x} - {pose_x_ff[POS_WIDTH-1], pose_x_ff};
   assign dy = {req_target_y[POS_WIDTH-1], req_target_y} - {pose_y_ff[POS_WIDTH-1], pose_y_ff};
   // A vector in the left half plane is turned by a half turn first.
   assign ux = dx[POS_WIDTH] ? -(POS_WIDTH+2)'(dx) : (POS_WIDTH+2)'(dx);
   assign uy = dx[POS_WIDTH] ? -(POS_WIDTH+2)'(dy) : (POS_WIDTH+2)'(dy);

   assign cv[0] = v0_ff;
   assign cx[0] = x0_ff;
   assign cy[0] = y0_ff;
   assign cz[0] = z0_ff;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
      wtm_cordic_cell #(.CW(CW), .IDX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .a_valid (cv[i]),
         .a_x     (cx[i]),
         .a_y     (cy[i]),
         .a_z     (cz[i]),
         .q_valid (cv[i+1]),
         .q_x     (cx[i+1]),
         .q_y     (cy[i+1]),
         .q_z     (cz[i+1])
      );
   end

   wtm_gain #(.POS_WIDTH(POS_WIDTH)) u_gain (
      .clock   (clock),
      .reset   (reset),
      .a_valid (cv[CORDIC_ITERS]),
      .a_x     (cx[CORDIC_ITERS]),
      .q_valid (gain_valid),
      .q_dist  (gain_dist)
   );

   assign zround   = cz[CORDIC_ITERS] + (32'd1 << (31 - ANGLE_WIDTH));
   assign bear_sel = zero_ff ? head_ff : bearing_ff;
   assign dist_sel = zero_ff ? '0 : gain_dist;
   assign turn1    = bear_sel - head_ff;
   assign turn2    = goal_ff - bear_sel;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CALC;
         ST_CALC: if (gain_valid) state_in = ST_EMIT;
         // The last command already sits in the output register.
         ST_EMIT: if (pend_ff == 3'b000) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
         v0_ff     <= 1'b0;
         pend_ff   <= 3'b000;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         v0_ff    <= accept;
         if (accept) begin
            pose_x_ff <= req_target_x;
            pose_y_ff <= req_target_y;
            pose_h_ff <= req_target_heading;
         end
         if (state_ff == ST_CALC && gain_valid) begin
            pend_ff <= {turn2 != '0, dist_sel != '0, turn1 != '0};
         end
         if (out_free) begin
            out_v_ff <= (state_ff == ST_EMIT) && (pend_ff != 3'b000);
            if (state_ff == ST_EMIT && pend_ff != 3'b000) begin
               if (pend_ff[0]) begin
                  pend_ff[0] <= 1'b0;
               end else if (pend_ff[1]) begin
                  pend_ff[1] <= 1'b0;
               end else begin
                  pend_ff[2] <= 1'b0;
               end
            end
         end
      end
      if (accept) begin
         head_ff <= pose_h_ff;
         goal_ff <= req_target_heading;
         zero_ff <= (dx == '0) && (dy == '0);
         x0_ff   <= CW'(ux) <<< GUARD;
         y0_ff   <= CW'(uy) <<< GUARD;
         z0_ff   <= dx[POS_WIDTH] ? 32'h8000_0000 : 32'h0000_0000;
      end
      if (cv[CORDIC_ITERS]) begin
         bearing_ff <= zround[31 -: ANGLE_WIDTH];
      end
      if (state_ff == ST_CALC && gain_valid) begin
         turn1_ff <= turn1;
         turn2_ff <= turn2;
         dist_ff  <= dist_sel;
      end
      if (out_free && state_ff == ST_EMIT && pend_ff != 3'b000) begin
         if (pend_ff[0]) begin
            out_kind_ff <= CMD_TURN;
            out_turn_ff <= turn1_ff;
            out_dist_ff <= '0;
            out_last_ff <= (pend_ff[2:1] == 2'b00);
         end else if (pend_ff[1]) begin
            out_kind_ff <= CMD_DRIVE;
            out_turn_ff <= '0;
            out_dist_ff <= dist_ff;
            out_last_ff <= !pend_ff[2];
         end else begin
            out_kind_ff <= CMD_TURN;
            out_turn_ff <= turn2_ff;
            out_dist_ff <= '0;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_command_kind   = out_kind_ff;
   assign rsp_turn_angle     = out_turn_ff;
   assign rsp_drive_distance = out_dist_ff;
   assign rsp_last_command   = out_last_ff;

endmodule

/* rtl/wtm_checker.sv */
// Port-level checks on the waypoint follower's command stream, bound to the top.
// Depends on wtm_pkg and waypoint_turn_move_commands_assert.svh.
module wtm_checker
   import wtm_pkg::*;
#(
   parameter int POS_WIDTH   = POS_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_command_kind,
   input logic [ANGLE_WIDTH-1:0] rsp_turn_angle,
   input logic [POS_WIDTH:0]     rsp_drive_distance,
   input logic                   rsp_last_command
);

`include "waypoint_turn_move_commands_assert.svh"

   `WTM_ASSERT_NXT_ALWAYS(a_reset_clears, reset, !rsp_valid, "item valid after reset")
   `WTM_ASSERT_NXT(a_stall_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_command_kind) && $stable(rsp_turn_angle) && $stable(rsp_drive_distance) && $stable(rsp_last_command), "stalled item changed")
   `WTM_ASSERT_IMP(a_drive_shape, rsp_valid && rsp_command_kind == CMD_DRIVE, rsp_turn_angle == '0 && rsp_drive_distance != '0, "malformed drive item")
   `WTM_ASSERT_IMP(a_turn_shape, rsp_valid && rsp_command_kind == CMD_TURN, rsp_turn_angle != '0 && rsp_drive_distance == '0, "malformed turn item")

endmodule

bind waypoint_turn_move_commands wtm_checker #(
   .POS_WIDTH   (POS_WIDTH),
   .ANGLE_WIDTH (ANGLE_WIDTH)
) u_wtm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_command_kind   (rsp_command_kind),
   .rsp_turn_angle     (rsp_turn_angle),
   .rsp_drive_distance (rsp_drive_distance),
   .rsp_last_command   (rsp_last_command)
);
